// ===== src/sws_pkg.sv =====
// Shared constants and codes for the sonar wall-follow steering block.
package sws_pkg;

  // Default sizes
  localparam int CAL_SAMPLES_DEF = 5;
  localparam int TIMER_BITS_DEF  = 16;

  // Field and register widths
  localparam int OP_W       = 2;
  localparam int SPEED_W    = 8;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int BYTE_W     = 8;

  // Echo width per centimeter, in microsecond ticks
  localparam int CM_DIVISOR = 58;

  localparam logic [LIMIT_W-1:0] INVALID_LIMIT_RST = LIMIT_W'(30000);
  localparam logic [BYTE_W-1:0]  BYTE_MAX          = '1;

  // Operation codes carried with each word
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMM_GAIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_LIMIT = 2'd3;

endpackage

// ===== src/sws_echo_timer.sv =====
// Echo pulse timer: counts high ticks and keeps the last completed pulse width.
module sws_echo_timer #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  logic                  level,
  output logic [TIMER_BITS-1:0] width,
  output logic [TIMER_BITS-1:0] width_next
);

  localparam logic [TIMER_BITS-1:0] RUN_MAX = '1;

  logic                  prev_level;
  logic [TIMER_BITS-1:0] running;
  logic [TIMER_BITS-1:0] running_next;

  always_comb begin
    running_next = running;
    width_next   = width;
    if (level) begin
      if (!prev_level) begin
        running_next = TIMER_BITS'(1);
      end else if (running != RUN_MAX) begin
        running_next = running + TIMER_BITS'(1);
      end
    end else if (prev_level) begin
      // falling edge: the pulse is complete
      width_next = running;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      running    <= '0;
      width      <= '0;
    end else if (tick) begin
      prev_level <= level;
      running    <= running_next;
      width      <= width_next;
    end
  end

endmodule

// ===== src/sonar_wall_follow_steering.sv =====
// Top level of the sonar wall-follow steering block.
//
//   channel  direction  handshake              payload
//   in       in         in_valid / in_ready    op, front_echo, rear_echo
//   out      out        out_valid / out_ready  left_effort, right_effort, front_cm,
//                                              rear_cm, front_invalid, rear_invalid,
//                                              calibrated
//   cfg      in         cfg_write              cfg_index, cfg_data
//
// One word is taken per clock while the output is not stalled; each word yields one result word.
// The pipeline has five stages: echo timing and calibration state,
// averaging and range scaling, error terms, gain multipliers, then sum and clamp.
// A stalled output backs up stage by stage; empty stages keep taking words.
// Synchronous reset clears all pipeline valid bits, timing and calibration state,
// and loads the register defaults (invalid limit 30000, all others zero).
module sonar_wall_follow_steering #(
  parameter int CAL_SAMPLES = sws_pkg::CAL_SAMPLES_DEF,
  parameter int TIMER_BITS  = sws_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write,
  input  logic [sws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sws_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sws_pkg::OP_W-1:0]        op,
  input  logic                            front_echo,
  input  logic                            rear_echo,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sws_pkg::BYTE_W-1:0]      left_effort,
  output logic [sws_pkg::BYTE_W-1:0]      right_effort,
  output logic [sws_pkg::BYTE_W-1:0]      front_cm,
  output logic [sws_pkg::BYTE_W-1:0]      rear_cm,
  output logic                            front_invalid,
  output logic                            rear_invalid,
  output logic                            calibrated
);

  import sws_pkg::*;

  // Calibration sums and round counter
  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W = TIMER_BITS + CNT_W;

  // Average by multiply with a rounded-up reciprocal; exact for every SUM_W-bit sum
  localparam int AVG_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
  localparam int AVG_MUL_W = SUM_W + 1;
  localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(
    ((64'd1 << AVG_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  // Range in cm by the same reciprocal scheme
  localparam int CM_SHIFT  = TIMER_BITS + $clog2(CM_DIVISOR);
  localparam int CM_MUL_W  = TIMER_BITS + 1;
  localparam int CM_PROD_W = TIMER_BITS + CM_MUL_W;
  localparam int CMQ_W     = CM_PROD_W - CM_SHIFT;
  localparam logic [CM_MUL_W-1:0] CM_MUL = CM_MUL_W'(
    ((64'd1 << CM_SHIFT) + 64'(CM_DIVISOR) - 64'd1) / 64'(CM_DIVISOR));

  // Steering arithmetic widths
  localparam int ERR_W  = TIMER_BITS + 2;
  localparam int PROD_W = GAIN_W + ERR_W;
  localparam int PSUM_W = PROD_W + 1;
  localparam int TERM_W = PSUM_W - 8;
  localparam int EFF_W  = TERM_W + 1;
  localparam int CMP_W  = TIMER_BITS + LIMIT_W;

  localparam logic [CNT_W-1:0] LAST_CAPTURE = CNT_W'(CAL_SAMPLES - 1);

  // ---------------------------------------------------------------- config
  logic [SPEED_W-1:0]        nominal_speed;
  logic signed [GAIN_W-1:0]  diff_gain;
  logic signed [GAIN_W-1:0]  comm_gain;
  logic [LIMIT_W-1:0]        invalid_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_speed <= '0;
      diff_gain     <= '0;
      comm_gain     <= '0;
      invalid_limit <= INVALID_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NOMINAL_SPEED: nominal_speed <= cfg_data[SPEED_W-1:0];
        REG_DIFF_GAIN:     diff_gain     <= $signed(cfg_data[GAIN_W-1:0]);
        REG_COMM_GAIN:     comm_gain     <= $signed(cfg_data[GAIN_W-1:0]);
        REG_INVALID_LIMIT: invalid_limit <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // Each stage loads when it is empty or the stage after it moves on.
  logic v1, v2, v3, v4;
  logic rdy2, rdy3, rdy4, rdy5;
  logic accept;

  assign rdy5     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign in_ready = !v1 || rdy2;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        out_valid <= v4;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Echo timing and calibration state advance on each accepted word; the
  // state registers then hold that word's view until stage 2 takes it.
  logic [TIMER_BITS-1:0] front_width, front_width_next;
  logic [TIMER_BITS-1:0] rear_width, rear_width_next;

  sws_echo_timer #(
    .TIMER_BITS (TIMER_BITS)
  ) u_front_timer (
    .clk        (clk),
    .rst        (rst),
    .tick       (accept),
    .level      (front_echo),
    .width      (front_width),
    .width_next (front_width_next)
  );

  sws_echo_timer #(
    .TIMER_BITS (TIMER_BITS)
  ) u_rear_timer (
    .clk        (clk),
    .rst        (rst),
    .tick       (accept),
    .level      (rear_echo),
    .width      (rear_width),
    .width_next (rear_width_next)
  );

  logic [SUM_W-1:0] front_sum, rear_sum;
  logic [SUM_W-1:0] front_sum_next, rear_sum_next;
  logic [CNT_W-1:0] capture_count;
  // Final round sums; the nominal widths are these divided by the sample count
  logic [SUM_W-1:0] front_nom_sum, rear_nom_sum;
  logic             cal_done;

  // Capture sums include the width updated by this same word
  assign front_sum_next = front_sum + SUM_W'(front_width_next);
  assign rear_sum_next  = rear_sum + SUM_W'(rear_width_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_sum     <= '0;
      rear_sum      <= '0;
      capture_count <= '0;
      front_nom_sum <= '0;
      rear_nom_sum  <= '0;
      cal_done      <= 1'b0;
    end else if (accept) begin
      priority if (op == OP_CAPTURE) begin
        if (capture_count == LAST_CAPTURE) begin
          // round complete: latch the totals, start a new round
          front_nom_sum <= front_sum_next;
          rear_nom_sum  <= rear_sum_next;
          cal_done      <= 1'b1;
          front_sum     <= '0;
          rear_sum      <= '0;
          capture_count <= '0;
        end else begin
          front_sum     <= front_sum_next;
          rear_sum      <= rear_sum_next;
          capture_count <= capture_count + CNT_W'(1);
        end
      end else if (op == OP_RESTART) begin
        front_sum     <= '0;
        rear_sum      <= '0;
        capture_count <= '0;
        front_nom_sum <= '0;
        rear_nom_sum  <= '0;
        cal_done      <= 1'b0;
      end else begin
        // plain tick (including the spare code): hold calibration state
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Nominal averages, ranges in cm and invalid flags.
  logic [AVG_PROD_W-1:0] front_avg_prod, rear_avg_prod;
  logic [CM_PROD_W-1:0]  front_cm_prod, rear_cm_prod;
  logic [CMQ_W-1:0]      front_cm_q, rear_cm_q;

  assign front_avg_prod = AVG_PROD_W'(front_nom_sum) * AVG_PROD_W'(AVG_MUL);
  assign rear_avg_prod  = AVG_PROD_W'(rear_nom_sum) * AVG_PROD_W'(AVG_MUL);
  assign front_cm_prod  = CM_PROD_W'(front_width) * CM_PROD_W'(CM_MUL);
  assign rear_cm_prod   = CM_PROD_W'(rear_width) * CM_PROD_W'(CM_MUL);
  assign front_cm_q     = front_cm_prod[CM_SHIFT +: CMQ_W];
  assign rear_cm_q      = rear_cm_prod[CM_SHIFT +: CMQ_W];

  logic [TIMER_BITS-1:0] wf2, wr2, nf2, nr2;
  logic [BYTE_W-1:0]     fcm2, rcm2;
  logic                  finv2, rinv2, cal2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      wf2   <= front_width;
      wr2   <= rear_width;
      nf2   <= front_avg_prod[AVG_SHIFT +: TIMER_BITS];
      nr2   <= rear_avg_prod[AVG_SHIFT +: TIMER_BITS];
      fcm2  <= (front_cm_q > CMQ_W'(BYTE_MAX)) ? BYTE_MAX : front_cm_q[BYTE_W-1:0];
      rcm2  <= (rear_cm_q > CMQ_W'(BYTE_MAX)) ? BYTE_MAX : rear_cm_q[BYTE_W-1:0];
      finv2 <= CMP_W'(front_width) > CMP_W'(invalid_limit);
      rinv2 <= CMP_W'(rear_width) > CMP_W'(invalid_limit);
      cal2  <= cal_done;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Difference and common-mode errors against the nominal widths.
  logic signed [ERR_W-1:0] de3, ce3;
  logic [BYTE_W-1:0]       fcm3, rcm3;
  logic                    finv3, rinv3, cal3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      de3   <= $signed(ERR_W'(wf2)) - $signed(ERR_W'(nf2))
             - $signed(ERR_W'(wr2)) + $signed(ERR_W'(nr2));
      ce3   <= $signed(ERR_W'(wf2)) - $signed(ERR_W'(nf2))
             + $signed(ERR_W'(wr2)) - $signed(ERR_W'(nr2));
      fcm3  <= fcm2;
      rcm3  <= rcm2;
      finv3 <= finv2;
      rinv3 <= rinv2;
      cal3  <= cal2;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Q8.8 gain products.
  logic signed [PROD_W-1:0] pd4, pc4;
  logic [BYTE_W-1:0]        fcm4, rcm4;
  logic                     finv4, rinv4, cal4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      pd4   <= PROD_W'(diff_gain) * PROD_W'(de3);
      pc4   <= PROD_W'(comm_gain) * PROD_W'(ce3);
      fcm4  <= fcm3;
      rcm4  <= rcm3;
      finv4 <= finv3;
      rinv4 <= rinv3;
      cal4  <= cal3;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Sum, floor to integer (arithmetic shift), offset by the nominal speed, clamp.
  logic signed [PSUM_W-1:0] psum;
  logic signed [TERM_W-1:0] term;
  logic signed [EFF_W-1:0]  speed_ext;
  logic signed [EFF_W-1:0]  left_raw, right_raw;
  logic [BYTE_W-1:0]        left_sat, right_sat;

  assign psum      = PSUM_W'(pd4) + PSUM_W'(pc4);
  assign term      = TERM_W'(psum >>> 8);
  assign speed_ext = $signed(EFF_W'(nominal_speed));
  assign left_raw  = speed_ext + EFF_W'(term);
  assign right_raw = speed_ext - EFF_W'(term);

  always_comb begin
    priority if (left_raw < 0) begin
      left_sat = '0;
    end else if (left_raw > $signed(EFF_W'(BYTE_MAX))) begin
      left_sat = BYTE_MAX;
    end else begin
      left_sat = left_raw[BYTE_W-1:0];
    end
    priority if (right_raw < 0) begin
      right_sat = '0;
    end else if (right_raw > $signed(EFF_W'(BYTE_MAX))) begin
      right_sat = BYTE_MAX;
    end else begin
      right_sat = right_raw[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      left_effort   <= left_sat;
      right_effort  <= right_sat;
      front_cm      <= fcm4;
      rear_cm       <= rcm4;
      front_invalid <= finv4;
      rear_invalid  <= rinv4;
      calibrated    <= cal4;
    end
  end

`ifndef SYNTH
  // The round counter wraps before it can reach the sample count
  assert property (@(posedge clk) disable iff (rst)
    accept |=> capture_count < CNT_W'(CAL_SAMPLES))
    else $error("capture count out of range");

  // A restart word always drops the calibration
  assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_RESTART |=> !cal_done && capture_count == '0)
    else $error("restart did not clear calibration");

  // The last capture of a round marks calibration done and starts a new round
  assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_CAPTURE && capture_count == LAST_CAPTURE
      |=> cal_done && capture_count == '0)
    else $error("calibration round did not complete");

  // With the output register empty the block must take a new word
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with output register empty");
`endif

endmodule
